### design/multi_ant_langton_step_top_defines.svh
`ifndef MULTI_ANT_LANGTON_STEP_TOP_DEFINES_SVH
`define MULTI_ANT_LANGTON_STEP_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define MALS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define MALS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mals_pkg.sv
package mals_pkg;

    localparam int GRID_DIM_DEF = 256;
    localparam int ANTS_DEF     = 16;

    localparam int POS_W     = 10;
    localparam int DIM_REG_W = 9;
    localparam int CNT_REG_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int OP_W      = 2;
    localparam int ID_W      = 4;
    localparam int COORD_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTS   = 2'd2;

    localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [CNT_REG_W-1:0] ANTS_RST   = 5'd1;

    localparam logic [1:0] HD_UP    = 2'd0;
    localparam logic [1:0] HD_RIGHT = 2'd1;
    localparam logic [1:0] HD_DOWN  = 2'd2;
    localparam logic [1:0] HD_LEFT  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_PLACE = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_FLIP,
        ST_SEE
    } t_state;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        t_pos       row;
        t_pos       col;
        logic [1:0] heading;
    } t_ant;

    function automatic logic [POS_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
                                                   input int hi);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == '0) return POS_W'(1);
        if (v32 > 32'(hi)) return POS_W'(hi);
        return POS_W'(v);
    endfunction

    function automatic logic [6:0] clamp_count(input logic [CNT_REG_W-1:0] v,
                                               input int hi);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == '0) return 7'd1;
        if (v32 > 32'(hi)) return 7'(hi);
        return 7'(v);
    endfunction

    function automatic logic on_grid(input t_pos row, input t_pos col,
                                     input logic [POS_W-1:0] h,
                                     input logic [POS_W-1:0] w);
        return !row[POS_W-1] && !col[POS_W-1]
               && ($unsigned(row) < h) && ($unsigned(col) < w);
    endfunction

endpackage

### design/multi_ant_langton_step_top.sv
// step word: each ant on the grid passes through fetch, flip and see, a frozen ant through
// fetch alone, after the word is taken in idle; a result is loaded in see, or in fetch
// for a frozen ant; output stalls hold the ant in see or fetch
// place and unused words are done in idle; clear grid runs a clearing pass over every row
// after reset a clearing pass blanks the grid, no word taken meanwhile
// registers and ants reset at once, config writes taken at any time
`include "multi_ant_langton_step_top_defines.svh"

module multi_ant_langton_step_top #(
    parameter int GRID_DIM = mals_pkg::GRID_DIM_DEF,
    parameter int ANTS     = mals_pkg::ANTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mals_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mals_pkg::CFG_DAT_W-1:0]       i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mals_pkg::OP_W-1:0]            i_operation,
    input  logic [mals_pkg::ID_W-1:0]            i_ant_index,
    input  logic [mals_pkg::COORD_W-1:0]         i_start_row,
    input  logic [mals_pkg::COORD_W-1:0]         i_start_col,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mals_pkg::ID_W-1:0]            o_ant_id,
    output logic signed [mals_pkg::POS_W-1:0]    o_ant_row,
    output logic signed [mals_pkg::POS_W-1:0]    o_ant_col,
    output logic [1:0]                           o_heading,
    output logic                                 o_moved,
    output logic                                 o_flipped_value,
    output logic                                 o_last
);

    localparam int RW = $clog2(GRID_DIM);
    localparam int AW = (ANTS > 1) ? $clog2(ANTS) : 1;
    localparam int CW = $clog2(ANTS + 1);

    mals_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_clr, n_clr;
    logic [AW-1:0]    r_k, n_k;
    mals_pkg::t_pos   r_row, n_row, r_col, n_col;
    logic [1:0]       r_hd, n_hd;
    logic             r_flip, n_flip;
    logic             r_new_on, n_new_on;

    logic [mals_pkg::DIM_REG_W-1:0] r_height, r_width;
    logic [mals_pkg::CNT_REG_W-1:0] r_ant_cnt;

    logic                          r_out_valid;
    logic [mals_pkg::ID_W-1:0]     r_out_id, n_out_id;
    mals_pkg::t_pos                r_out_row, n_out_row, r_out_col, n_out_col;
    logic [1:0]                    r_out_hd, n_out_hd;
    logic                          r_out_moved, n_out_moved;
    logic                          r_out_flip, n_out_flip;
    logic                          r_out_last, n_out_last;
    logic                          out_load;

    logic                mem_we;
    logic [RW-1:0]       mem_waddr, mem_raddr;
    logic [GRID_DIM-1:0] mem_wdata, mem_rdata, wmask;

    logic           ant_we;
    logic [AW-1:0]  ant_waddr;
    mals_pkg::t_ant ant_wdata, cur;

    logic [mals_pkg::POS_W-1:0] h_lim, w_lim;
    logic [CW-1:0]  n_lim;
    logic           cur_on, is_last, out_space, in_acc, place_ok, seen;
    logic [1:0]     turned;
    mals_pkg::t_pos nx_row, nx_col;
    logic [31:0]    place_idx32, k32;
    mals_pkg::t_op  op;

    mals_grid_mem #(.GRID_DIM(GRID_DIM)) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mals_ant_file #(.ANTS(ANTS)) u_ants (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ant_we),
        .i_waddr (ant_waddr),
        .i_wdata (ant_wdata),
        .i_raddr (r_k),
        .o_rdata (cur)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= mals_pkg::HEIGHT_RST;
            r_width   <= mals_pkg::WIDTH_RST;
            r_ant_cnt <= mals_pkg::ANTS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mals_pkg::CFG_HEIGHT: r_height  <= i_cfg_data;
                mals_pkg::CFG_WIDTH:  r_width   <= i_cfg_data;
                mals_pkg::CFG_ANTS:   r_ant_cnt <= i_cfg_data[mals_pkg::CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign h_lim       = mals_pkg::clamp_dim(r_height, GRID_DIM);
    assign w_lim       = mals_pkg::clamp_dim(r_width, GRID_DIM);
    assign n_lim       = CW'(mals_pkg::clamp_count(r_ant_cnt, ANTS));
    assign cur_on      = mals_pkg::on_grid(cur.row, cur.col, h_lim, w_lim);
    assign is_last     = (CW'(r_k) + CW'(1)) == n_lim;
    assign out_space   = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign op          = mals_pkg::t_op'(i_operation);
    assign place_idx32 = 32'(i_ant_index);
    assign place_ok    = place_idx32 < 32'(ANTS);
    assign k32         = 32'(r_k);
    assign wmask       = GRID_DIM'(1) << r_col[RW-1:0];
    // the cell reached never equals the one just flipped, so a same-row read is safe
    assign seen        = r_new_on && mem_rdata[r_col[RW-1:0]];
    assign turned      = seen ? (r_hd - 2'd1) : (r_hd + 2'd1);

    always_comb begin
        nx_row = r_row;
        nx_col = r_col;
        unique case (r_hd)
            mals_pkg::HD_UP:    nx_row = r_row - mals_pkg::t_pos'(1);
            mals_pkg::HD_RIGHT: nx_col = r_col + mals_pkg::t_pos'(1);
            mals_pkg::HD_DOWN:  nx_row = r_row + mals_pkg::t_pos'(1);
            mals_pkg::HD_LEFT:  nx_col = r_col - mals_pkg::t_pos'(1);
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mals_pkg::ST_CLEAR: begin
                if (r_clr == RW'(GRID_DIM - 1)) n_state = mals_pkg::ST_IDLE;
            end
            mals_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (op)
                        mals_pkg::OP_CLEAR: n_state = mals_pkg::ST_CLEAR;
                        mals_pkg::OP_STEP:  n_state = mals_pkg::ST_FETCH;
                        default: ;
                    endcase
                end
            end
            mals_pkg::ST_FETCH: begin
                if (cur_on) begin
                    n_state = mals_pkg::ST_FLIP;
                end else if (out_space && is_last) begin
                    n_state = mals_pkg::ST_IDLE;
                end
            end
            mals_pkg::ST_FLIP: n_state = mals_pkg::ST_SEE;
            mals_pkg::ST_SEE: begin
                if (out_space) begin
                    n_state = is_last ? mals_pkg::ST_IDLE : mals_pkg::ST_FETCH;
                end
            end
            default: n_state = mals_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_row[RW-1:0];
        mem_wdata   = mem_rdata ^ wmask;
        mem_raddr   = r_row[RW-1:0];
        ant_we      = 1'b0;
        ant_waddr   = r_k;
        ant_wdata   = '{row: r_row, col: r_col, heading: turned};
        out_load    = 1'b0;
        n_out_id    = k32[mals_pkg::ID_W-1:0];
        n_out_row   = r_row;
        n_out_col   = r_col;
        n_out_hd    = turned;
        n_out_moved = 1'b1;
        n_out_flip  = r_flip;
        n_out_last  = is_last;
        n_clr       = r_clr;
        n_k         = r_k;
        n_row       = r_row;
        n_col       = r_col;
        n_hd        = r_hd;
        n_flip      = r_flip;
        n_new_on    = r_new_on;
        unique case (r_state)
            mals_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + RW'(1);
            end
            mals_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_clr      = '0;
                n_k        = '0;
                if (in_acc && op == mals_pkg::OP_PLACE && place_ok) begin
                    ant_we    = 1'b1;
                    ant_waddr = place_idx32[AW-1:0];
                    ant_wdata = '{row:     mals_pkg::t_pos'(i_start_row),
                                  col:     mals_pkg::t_pos'(i_start_col),
                                  heading: mals_pkg::HD_UP};
                end
            end
            mals_pkg::ST_FETCH: begin
                mem_raddr = cur.row[RW-1:0];
                n_row     = cur.row;
                n_col     = cur.col;
                n_hd      = cur.heading;
                if (!cur_on && out_space) begin
                    out_load    = 1'b1;
                    n_out_row   = cur.row;
                    n_out_col   = cur.col;
                    n_out_hd    = cur.heading;
                    n_out_moved = 1'b0;
                    n_out_flip  = 1'b0;
                    n_k         = r_k + AW'(1);
                end
            end
            mals_pkg::ST_FLIP: begin
                mem_we    = 1'b1;
                mem_raddr = nx_row[RW-1:0];
                n_flip    = !mem_rdata[r_col[RW-1:0]];
                n_row     = nx_row;
                n_col     = nx_col;
                n_new_on  = mals_pkg::on_grid(nx_row, nx_col, h_lim, w_lim);
            end
            mals_pkg::ST_SEE: begin
                if (out_space) begin
                    out_load = 1'b1;
                    ant_we   = 1'b1;
                    n_k      = r_k + AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mals_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_hd     <= n_hd;
        r_flip   <= n_flip;
        r_new_on <= n_new_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id    <= n_out_id;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_hd    <= n_out_hd;
            r_out_moved <= n_out_moved;
            r_out_flip  <= n_out_flip;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ant_id        = r_out_id;
    assign o_ant_row       = r_out_row;
    assign o_ant_col       = r_out_col;
    assign o_heading       = r_out_hd;
    assign o_moved         = r_out_moved;
    assign o_flipped_value = r_out_flip;
    assign o_last          = r_out_last;

    `MALS_ASSERT(a_we_state, i_clk, i_rst_n, mem_we, (r_state == mals_pkg::ST_FLIP || r_state == mals_pkg::ST_CLEAR), "grid written outside flip or clear")
    `MALS_ASSERT(a_flip_after_fetch, i_clk, i_rst_n, (r_state == mals_pkg::ST_FLIP), ($past(r_state) == mals_pkg::ST_FETCH), "flip not preceded by fetch")
    `MALS_ASSERT(a_frozen_flip, i_clk, i_rst_n, (o_out_valid && !o_moved), (!o_flipped_value), "frozen ant reports a flipped cell")
    `MALS_ASSERT_NEXT(a_clear_runs, i_clk, i_rst_n, (r_state == mals_pkg::ST_CLEAR && r_clr != RW'(GRID_DIM - 1)), (r_state == mals_pkg::ST_CLEAR), "clearing pass cut short")

endmodule

### design/mals_grid_mem.sv
module mals_grid_mem #(
    parameter int  GRID_DIM = mals_pkg::GRID_DIM_DEF,
    localparam int RW       = $clog2(GRID_DIM)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [RW-1:0]       i_waddr,
    input  logic [GRID_DIM-1:0] i_wdata,
    input  logic [RW-1:0]       i_raddr,
    output logic [GRID_DIM-1:0] o_rdata
);

    // one row of cells per word, read before write on a shared address
    logic [GRID_DIM-1:0] r_mem [GRID_DIM];
    logic [GRID_DIM-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mals_ant_file.sv
module mals_ant_file #(
    parameter int  ANTS = mals_pkg::ANTS_DEF,
    localparam int AW   = (ANTS > 1) ? $clog2(ANTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  mals_pkg::t_ant  i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output mals_pkg::t_ant  o_rdata
);

    mals_pkg::t_ant r_ant [ANTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ANTS; i++) begin
                r_ant[i] <= '0;
            end
        end else if (i_we) begin
            r_ant[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_ant[i_raddr];

endmodule

### test/tb_multi_ant_langton_step_top.sv
module tb_multi_ant_langton_step_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID          = mals_pkg::GRID_DIM_DEF;
    localparam int ANT_MAX       = mals_pkg::ANTS_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [mals_pkg::OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [mals_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [mals_pkg::ID_W-1:0] id;
        mals_pkg::t_pos            row;
        mals_pkg::t_pos            col;
        logic [1:0]                hd;
        logic                      moved;
        logic                      flipped;
        logic                      last;
    } t_ant_report;

    logic                                i_clk;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_valid     = 1'b0;
    logic [mals_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [mals_pkg::CFG_DAT_W-1:0]      i_cfg_data      = '0;
    logic                                i_in_valid      = 1'b0;
    logic [mals_pkg::OP_W-1:0]           i_operation     = '0;
    logic [mals_pkg::ID_W-1:0]           i_ant_index     = '0;
    logic [mals_pkg::COORD_W-1:0]        i_start_row     = '0;
    logic [mals_pkg::COORD_W-1:0]        i_start_col     = '0;
    logic                                i_out_ready     = 1'b0;
    logic                                o_cfg_ready;
    logic                                o_in_ready;
    logic                                o_out_valid;
    logic [mals_pkg::ID_W-1:0]           o_ant_id;
    logic signed [mals_pkg::POS_W-1:0]   o_ant_row;
    logic signed [mals_pkg::POS_W-1:0]   o_ant_col;
    logic [1:0]                          o_heading;
    logic                                o_moved;
    logic                                o_flipped_value;
    logic                                o_last;

    multi_ant_langton_step_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_ant_index     (i_ant_index),
        .i_start_row     (i_start_row),
        .i_start_col     (i_start_col),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ant_id        (o_ant_id),
        .o_ant_row       (o_ant_row),
        .o_ant_col       (o_ant_col),
        .o_heading       (o_heading),
        .o_moved         (o_moved),
        .o_flipped_value (o_flipped_value),
        .o_last          (o_last)
    );

    // predicted block state
    bit                             grid_bits [GRID*GRID];
    int                             ant_r [ANT_MAX];
    int                             ant_c [ANT_MAX];
    logic [1:0]                     ant_hd [ANT_MAX];
    logic [mals_pkg::DIM_REG_W-1:0] reg_height;
    logic [mals_pkg::DIM_REG_W-1:0] reg_width;
    logic [mals_pkg::CNT_REG_W-1:0] reg_ants;

    t_ant_report expected_reports [$];

    int err_count    = 0;
    int n_words      = 0;
    int n_steps      = 0;
    int n_reports    = 0;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int eff_dim(input logic [mals_pkg::DIM_REG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > GRID) return GRID;
        return int'(v);
    endfunction

    function automatic int eff_ants(input logic [mals_pkg::CNT_REG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > ANT_MAX) return ANT_MAX;
        return int'(v);
    endfunction

    function automatic bit in_bounds(input int r, input int c);
        return r >= 0 && r < eff_dim(reg_height) && c >= 0 && c < eff_dim(reg_width);
    endfunction

    task automatic step_ants;
        int          n;
        int          r;
        int          c;
        logic [1:0]  hd;
        bit          seen;
        t_ant_report rep;
        n = eff_ants(reg_ants);
        for (int k = 0; k < n; k++) begin
            r = ant_r[k];
            c = ant_c[k];
            hd = ant_hd[k];
            rep.moved = 1'b0;
            rep.flipped = 1'b0;
            if (in_bounds(r, c)) begin
                grid_bits[r*GRID + c] ^= 1'b1;
                rep.flipped = grid_bits[r*GRID + c];
                rep.moved = 1'b1;
                case (hd)
                    mals_pkg::HD_UP:    r--;
                    mals_pkg::HD_RIGHT: c++;
                    mals_pkg::HD_DOWN:  r++;
                    default:            c--;
                endcase
                seen = in_bounds(r, c) ? grid_bits[r*GRID + c] : 1'b0;
                hd = seen ? hd - 2'd1 : hd + 2'd1;
                ant_r[k] = r;
                ant_c[k] = c;
                ant_hd[k] = hd;
            end
            rep.id = mals_pkg::ID_W'(k);
            rep.row = mals_pkg::t_pos'(r);
            rep.col = mals_pkg::t_pos'(c);
            rep.hd = hd;
            rep.last = (k == n - 1);
            expected_reports.push_back(rep);
        end
    endtask

    task automatic predict_word(input logic [mals_pkg::OP_W-1:0] op,
                                input logic [mals_pkg::ID_W-1:0] idx,
                                input logic [mals_pkg::COORD_W-1:0] row,
                                input logic [mals_pkg::COORD_W-1:0] col);
        case (op)
            mals_pkg::OP_CLEAR: grid_bits = '{default: 1'b0};
            mals_pkg::OP_PLACE: begin
                if (int'(idx) < ANT_MAX) begin
                    ant_r[idx] = int'(row);
                    ant_c[idx] = int'(col);
                    ant_hd[idx] = mals_pkg::HD_UP;
                end
            end
            mals_pkg::OP_STEP: step_ants();
            default: ;
        endcase
    endtask

    // sender: valid stays up after acceptance until the next call or settle
    task automatic send_word(input logic [mals_pkg::OP_W-1:0] op,
                             input logic [mals_pkg::ID_W-1:0] idx,
                             input logic [mals_pkg::COORD_W-1:0] row,
                             input logic [mals_pkg::COORD_W-1:0] col);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_ant_index <= idx;
        i_start_row <= row;
        i_start_col <= col;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(op, idx, row, col);
        if (op != OP_SPARE) n_words++;
        if (op == mals_pkg::OP_STEP) n_steps++;
    endtask

    task automatic settle;
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [mals_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mals_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mals_pkg::CFG_HEIGHT: reg_height = data;
            mals_pkg::CFG_WIDTH:  reg_width  = data;
            mals_pkg::CFG_ANTS:   reg_ants   = data[mals_pkg::CNT_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [mals_pkg::CFG_DAT_W-1:0] h,
                                input logic [mals_pkg::CFG_DAT_W-1:0] w,
                                input logic [mals_pkg::CFG_DAT_W-1:0] n);
        settle();
        cfg_write(mals_pkg::CFG_HEIGHT, h);
        cfg_write(mals_pkg::CFG_WIDTH, w);
        cfg_write(mals_pkg::CFG_ANTS, n);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [10:0] want,
                               input logic signed [10:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_reports
        t_ant_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("ant report for ant %0d with none expected", o_ant_id);
                err_count++;
            end else begin
                want = expected_reports.pop_front();
                n_reports++;
                check_field("ant_id", want.id, o_ant_id);
                check_field("ant_row", want.row, o_ant_row);
                check_field("ant_col", want.col, o_ant_col);
                check_field("heading", want.hd, o_heading);
                check_field("moved", want.moved, o_moved);
                check_field("flipped_value", want.flipped, o_flipped_value);
                check_field("last", want.last, o_last);
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    function automatic logic [mals_pkg::CFG_DAT_W-1:0] pick_dim;
        case ($urandom_range(9))
            0:       return '0;
            1:       return mals_pkg::CFG_DAT_W'($urandom_range(GRID + 1, 511));
            2:       return mals_pkg::CFG_DAT_W'(GRID);
            default: return mals_pkg::CFG_DAT_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [mals_pkg::CFG_DAT_W-1:0] pick_count;
        case ($urandom_range(9))
            0:       return '0;
            1:       return mals_pkg::CFG_DAT_W'($urandom_range(ANT_MAX + 1, 31));
            default: return mals_pkg::CFG_DAT_W'($urandom_range(1, ANT_MAX));
        endcase
    endfunction

    function automatic logic [mals_pkg::COORD_W-1:0] pick_coord(input int dim);
        if ($urandom_range(9) == 0) return mals_pkg::COORD_W'($urandom);
        return mals_pkg::COORD_W'($urandom_range(dim - 1));
    endfunction

    task automatic test_default_registers;
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
        send_word(mals_pkg::OP_STEP, '1, '1, '1);
    endtask

    task automatic test_full_grid_many_ants;
        program_regs(9'h1FF, 9'd256, 9'd16);
        send_word(mals_pkg::OP_PLACE, 4'd15, 8'd255, 8'd255);
        send_word(mals_pkg::OP_PLACE, 4'd0, 8'd128, 8'd128);
        send_word(mals_pkg::OP_PLACE, 4'd1, 8'd128, 8'd128);
        send_word(mals_pkg::OP_PLACE, 4'd2, 8'd0, 8'd255);
        send_word(mals_pkg::OP_PLACE, 4'd3, 8'd255, 8'd0);
        repeat (3) send_word(mals_pkg::OP_STEP, '0, '0, '0);
        send_word(OP_SPARE, '1, '1, '1);
        send_word(mals_pkg::OP_CLEAR, '0, '0, '0);
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
    endtask

    task automatic test_tiny_grid;
        settle();
        cfg_write(CFG_SPARE, 9'h1FF);
        cfg_write(mals_pkg::CFG_HEIGHT, '0);
        cfg_write(mals_pkg::CFG_WIDTH, '0);
        cfg_write(mals_pkg::CFG_ANTS, '0);
        i_cfg_valid <= 1'b0;
        send_word(mals_pkg::OP_PLACE, 4'd0, 8'd0, 8'd0);
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
        send_word(mals_pkg::OP_PLACE, 4'd0, 8'd200, 8'd7);
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
    endtask

    // a set cell beyond the used columns reads clear but keeps its bit
    task automatic test_shrunk_grid;
        program_regs(9'd256, 9'd256, 9'd1);
        send_word(mals_pkg::OP_PLACE, 4'd0, 8'd10, 8'd4);
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
        program_regs(9'd256, 9'd4, 9'd1);
        send_word(mals_pkg::OP_PLACE, 4'd0, 8'd11, 8'd3);
        repeat (2) send_word(mals_pkg::OP_STEP, '0, '0, '0);
        program_regs(9'd256, 9'd256, 9'd1);
        send_word(mals_pkg::OP_STEP, '0, '0, '0);
    endtask

    task automatic test_random_walks(input int in_pct, input int out_pct, input int words);
        int target;
        int h;
        int w;
        int nsteps;
        target = n_words + words;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        while (n_words < target) begin
            program_regs(pick_dim(), pick_dim(), pick_count());
            h = eff_dim(reg_height);
            w = eff_dim(reg_width);
            if ($urandom_range(3) != 0)
                send_word(mals_pkg::OP_CLEAR, mals_pkg::ID_W'($urandom), '0, '0);
            for (int k = 0; k < eff_ants(reg_ants); k++) begin
                if ($urandom_range(4) != 0)
                    send_word(mals_pkg::OP_PLACE, mals_pkg::ID_W'(k), pick_coord(h),
                              pick_coord(w));
            end
            nsteps = $urandom_range(6, 14);
            for (int s = 0; s < nsteps; s++) begin
                case ($urandom_range(99)) inside
                    [0:3]:   send_word(mals_pkg::OP_PLACE, mals_pkg::ID_W'($urandom),
                                       pick_coord(h), pick_coord(w));
                    [4:6]:   send_word(OP_SPARE, mals_pkg::ID_W'($urandom),
                                       mals_pkg::COORD_W'($urandom),
                                       mals_pkg::COORD_W'($urandom));
                    7:       send_word(mals_pkg::OP_CLEAR, '0, '0, '0);
                    default: send_word(mals_pkg::OP_STEP, mals_pkg::ID_W'($urandom),
                                       mals_pkg::COORD_W'($urandom),
                                       mals_pkg::COORD_W'($urandom));
                endcase
            end
        end
    endtask

    task automatic test_output_stall;
        in_idle_pct = 0;
        out_idle_pct = 0;
        program_regs(9'd256, 9'd256, 9'd16);
        send_word(mals_pkg::OP_CLEAR, '0, '0, '0);
        for (int k = 0; k < ANT_MAX; k++)
            send_word(mals_pkg::OP_PLACE, mals_pkg::ID_W'(k),
                      mals_pkg::COORD_W'($urandom_range(100, 150)),
                      mals_pkg::COORD_W'($urandom_range(100, 150)));
        hold_asked <= hold_asked + 1;
        repeat (10) send_word(mals_pkg::OP_STEP, '0, '0, '0);
    endtask

    initial begin
        grid_bits = '{default: 1'b0};
        foreach (ant_r[k]) begin
            ant_r[k] = 0;
            ant_c[k] = 0;
            ant_hd[k] = mals_pkg::HD_UP;
        end
        reg_height = mals_pkg::HEIGHT_RST;
        reg_width  = mals_pkg::WIDTH_RST;
        reg_ants   = mals_pkg::ANTS_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_pct = 12;
        out_idle_pct = 47;
        settle();
        test_default_registers();
        test_full_grid_many_ants();
        test_tiny_grid();
        test_shrunk_grid();
        test_random_walks(12, 47, 50);
        test_random_walks(47, 12, 50);
        test_random_walks(0, 0, 50);
        test_output_stall();
        settle();
        $display("run covered %0d words (%0d steps) and %0d ant reports checked",
                 n_words, n_steps, n_reports);
        $display("grids 1x1 to full size, register values out of range, frozen ants, long stall");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### multi_ant_langton_step_top.f
+incdir+design
design/mals_pkg.sv
design/mals_grid_mem.sv
design/mals_ant_file.sv
design/multi_ant_langton_step_top.sv
test/tb_multi_ant_langton_step_top.sv
